// ----- sv/plpg_pkg.sv -----
// Types, constants and the control store of the profile generator sequencer.
// Used by piecewise_linear_profile_generator; depends on nothing else.
package plpg_pkg;

  localparam int SW  = 5;    // step counter width
  localparam int QB  = 16;   // quotient bits per divide pass
  localparam int RW  = 47;   // divider remainder width
  localparam logic [6:0] PCT = 7'd100;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // one setpoint as stored in the table
  typedef struct packed {
    logic [30:0]        tm;
    logic signed [15:0] tp;
    logic [7:0]         fn;
  } ent_t;

  typedef enum logic [4:0] {
    A_NONE, A_LATCH, A_CLEAR, A_ADD, A_START, A_RD_REQ, A_RD_TAKE, A_Q_INIT,
    A_WALK, A_MUL_TEMP, A_DIV, A_FIX_TEMP, A_FIX_FAN, A_HOLD, A_PROG,
    A_FIX_PROG, A_EMIT
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NOSTART, C_OPCODE, C_SINGLE, C_WALK, C_NOTFOUND,
    C_DIV_MORE, C_PROG_FULL
  } cond_t;

  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic [SW-1:0]   tgt;
  } ucw_t;

  localparam logic [SW-1:0] S_IDLE  = 5'd0;
  localparam logic [SW-1:0] S_DISP  = 5'd1;
  localparam logic [SW-1:0] S_CLEAR = 5'd2;
  localparam logic [SW-1:0] S_ADD   = 5'd3;
  localparam logic [SW-1:0] S_START = 5'd4;
  localparam logic [SW-1:0] S_RD    = 5'd5;
  localparam logic [SW-1:0] S_RD2   = 5'd6;
  localparam logic [SW-1:0] S_QINIT = 5'd7;
  localparam logic [SW-1:0] S_WALK  = 5'd8;
  localparam logic [SW-1:0] S_CHK   = 5'd9;
  localparam logic [SW-1:0] S_MULT  = 5'd10;
  localparam logic [SW-1:0] S_DIVT  = 5'd11;
  localparam logic [SW-1:0] S_FIXT  = 5'd12;
  localparam logic [SW-1:0] S_DIVF  = 5'd13;
  localparam logic [SW-1:0] S_FIXF  = 5'd14;
  localparam logic [SW-1:0] S_HOLD  = 5'd15;
  localparam logic [SW-1:0] S_PROG  = 5'd16;
  localparam logic [SW-1:0] S_DIVP  = 5'd17;
  localparam logic [SW-1:0] S_FIXP  = 5'd18;
  localparam logic [SW-1:0] S_EMIT  = 5'd19;

  function automatic ucw_t ucode(input logic [SW-1:0] s);
    ucw_t w;
    case (s)
      S_IDLE:  w = '{A_LATCH,    C_NOSTART,   S_IDLE};
      S_DISP:  w = '{A_NONE,     C_OPCODE,    S_IDLE};
      S_CLEAR: w = '{A_CLEAR,    C_ALWAYS,    S_EMIT};
      S_ADD:   w = '{A_ADD,      C_ALWAYS,    S_EMIT};
      S_START: w = '{A_START,    C_ALWAYS,    S_EMIT};
      S_RD:    w = '{A_RD_REQ,   C_NEVER,     S_IDLE};
      S_RD2:   w = '{A_RD_TAKE,  C_ALWAYS,    S_EMIT};
      S_QINIT: w = '{A_Q_INIT,   C_SINGLE,    S_HOLD};
      S_WALK:  w = '{A_WALK,     C_WALK,      S_WALK};
      S_CHK:   w = '{A_NONE,     C_NOTFOUND,  S_HOLD};
      S_MULT:  w = '{A_MUL_TEMP, C_NEVER,     S_IDLE};
      S_DIVT:  w = '{A_DIV,      C_DIV_MORE,  S_DIVT};
      S_FIXT:  w = '{A_FIX_TEMP, C_NEVER,     S_IDLE};
      S_DIVF:  w = '{A_DIV,      C_DIV_MORE,  S_DIVF};
      S_FIXF:  w = '{A_FIX_FAN,  C_ALWAYS,    S_PROG};
      S_HOLD:  w = '{A_HOLD,     C_NEVER,     S_IDLE};
      S_PROG:  w = '{A_PROG,     C_PROG_FULL, S_EMIT};
      S_DIVP:  w = '{A_DIV,      C_DIV_MORE,  S_DIVP};
      S_FIXP:  w = '{A_FIX_PROG, C_NEVER,     S_IDLE};
      S_EMIT:  w = '{A_EMIT,     C_ALWAYS,    S_IDLE};
      default: w = '{A_NONE,     C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

  // entry point of each opcode routine
  function automatic logic [SW-1:0] dispatch(input logic [2:0] op);
    logic [SW-1:0] t;
    case (op)
      OP_CLEAR: t = S_CLEAR;
      OP_ADD:   t = S_ADD;
      OP_START: t = S_START;
      OP_QUERY: t = S_QINIT;
      OP_READ:  t = S_RD;
      default:  t = S_EMIT;
    endcase
    return t;
  endfunction

endpackage

// ----- sv/piecewise_linear_profile_generator.sv -----
// Ramp/soak profile generator: setpoint table, microcoded sequencer and a shared
// shift-subtract divider. Depends on plpg_pkg.
//
// A request is taken when start is high and busy is low; its single result appears
// on the result ports for exactly one cycle with done high, and the receiver cannot
// stall it. A query walks the table one entry per cycle (one memory read port) and
// then runs the restoring divider three times, for temperature, fan and progress;
// past the last setpoint both interpolation passes are skipped, and a profile at or
// past its end skips the progress pass. busy stays high from the request until the
// cycle of done, during which the next request can be taken.
module piecewise_linear_profile_generator
  import plpg_pkg::*;
#(
  parameter int MAX_POINTS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           opcode,
  input  logic [31:0]                          time_ms,
  input  logic signed [15:0]                   temp,
  input  logic [7:0]                           fan,
  input  logic [3:0]                           index,
  output logic                                 done,
  output logic signed [15:0]                   target_temp,
  output logic [7:0]                           target_fan,
  output logic [30:0]                          entry_time,
  output logic [6:0]                           progress,
  output logic signed [15:0]                   final_temp,
  output logic [$clog2(MAX_POINTS+1)-1:0]      entry_count,
  output logic                                 entry_valid
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int XW = (CW > 4) ? CW : 4;

  // control state
  logic [SW-1:0]      step;
  logic [SW-1:0]      step_next;
  logic [CW-1:0]      cnt;
  logic [31:0]        start_tick;
  logic signed [15:0] temp0;
  logic signed [15:0] last_temp;
  logic [30:0]        last_time;

  // datapath
  logic [2:0]         op_r;
  logic [31:0]        tms_r;
  logic signed [15:0] tval_r;
  logic [7:0]         fval_r;
  logic [3:0]         idx_r;
  logic [31:0]        el;
  logic [AW-1:0]      ptr;
  ent_t               prv;
  logic               found;
  logic               neg;
  logic [30:0]        span;
  logic [RW-1:0]      r;
  logic [RW-1:0]      dsh;
  logic [QB-1:0]      q;
  logic [3:0]         k;

  ent_t               mem [MAX_POINTS];
  ent_t               rd_q;
  logic [AW-1:0]      rd_addr;

  ucw_t               uc;
  logic               jmp;
  logic               hit;
  logic               more;
  logic               full;
  logic               tbl_full;
  logic               idx_ok;
  logic [30:0]        off;
  logic [30:0]        span_c;
  logic signed [16:0] dt;
  logic [16:0]        mag_t;
  logic signed [8:0]  df;
  logic [8:0]         mag_f;
  logic [RW-1:0]      prod_t;
  logic [RW-1:0]      prod_f;
  logic [38:0]        pct;
  logic               ge;
  logic [QB:0]        qn;

  assign uc          = ucode(step);
  assign busy        = (step != S_IDLE);
  assign final_temp  = last_temp;
  assign entry_count = cnt;

  assign hit      = ({1'b0, rd_q.tm} > el);
  assign more     = ((CW'(ptr) + CW'(1)) < cnt);
  assign full     = (el >= {1'b0, last_time});
  assign tbl_full = (cnt >= CW'(MAX_POINTS));
  assign idx_ok   = (XW'(idx_r) < XW'(cnt));

  assign off    = el[30:0] - prv.tm;
  assign span_c = rd_q.tm - prv.tm;
  assign dt     = {rd_q.tp[15], rd_q.tp} - {prv.tp[15], prv.tp};
  assign mag_t  = dt[16] ? 17'(-dt) : 17'(dt);
  assign df     = {1'b0, rd_q.fn} - {1'b0, prv.fn};
  assign mag_f  = df[8] ? 9'(-df) : 9'(df);
  assign prod_t = RW'(mag_t[15:0] * off);
  assign prod_f = RW'(mag_f[7:0] * off);
  assign pct    = 39'(el) * 39'(PCT);
  assign ge     = (r >= dsh);
  // floor of a signed quotient: negate, and step down once more on a remainder
  assign qn     = !neg ? {1'b0, q} : ((r != '0) ? ~{1'b0, q} : -{1'b0, q});

  always_comb begin
    case (uc.cond)
      C_NEVER:     jmp = 1'b0;
      C_ALWAYS:    jmp = 1'b1;
      C_NOSTART:   jmp = !start;
      C_SINGLE:    jmp = (cnt == CW'(1));
      C_WALK:      jmp = !hit && more;
      C_NOTFOUND:  jmp = !found;
      C_DIV_MORE:  jmp = (k != 4'd0);
      C_PROG_FULL: jmp = full;
      default:     jmp = 1'b0;
    endcase
    if (uc.cond == C_OPCODE) begin
      step_next = dispatch(op_r);
    end else if (jmp) begin
      step_next = uc.tgt;
    end else begin
      step_next = step + SW'(1);
    end
  end

  always_comb begin
    case (uc.act)
      A_RD_REQ: rd_addr = AW'(XW'(idx_r));
      A_Q_INIT: rd_addr = AW'(1);
      A_WALK:   rd_addr = hit ? ptr : ptr + AW'(1);
      default:  rd_addr = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uc.act == A_ADD && !tbl_full) begin
      mem[AW'(cnt)] <= '{tm: tms_r[30:0], tp: tval_r, fn: fval_r};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= S_IDLE;
      cnt        <= CW'(1);
      start_tick <= '0;
      temp0      <= '0;
      last_temp  <= '0;
      last_time  <= '0;
      done       <= 1'b0;
    end else begin
      step <= step_next;
      done <= (uc.act == A_EMIT);
      case (uc.act)
        A_CLEAR: begin
          cnt       <= CW'(1);
          temp0     <= '0;
          last_temp <= '0;
          last_time <= '0;
        end
        A_ADD: begin
          if (!tbl_full) begin
            cnt       <= cnt + CW'(1);
            last_time <= tms_r[30:0];
            last_temp <= tval_r;
          end
        end
        A_START: begin
          start_tick <= tms_r;
          temp0      <= tval_r;
          if (cnt == CW'(1)) begin
            last_temp <= tval_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uc.act)
      A_LATCH: begin
        if (start) begin
          op_r        <= opcode;
          tms_r       <= time_ms;
          tval_r      <= temp;
          fval_r      <= fan;
          idx_r       <= index;
          el          <= time_ms - start_tick;
          target_temp <= '0;
          target_fan  <= '0;
          entry_time  <= '0;
          progress    <= '0;
          entry_valid <= 1'b1;
        end
      end
      A_RD_TAKE: begin
        entry_valid <= idx_ok;
        if (idx_ok) begin
          if (idx_r == 4'd0) begin
            target_temp <= temp0;
          end else begin
            target_temp <= rd_q.tp;
            target_fan  <= rd_q.fn;
            entry_time  <= rd_q.tm;
          end
        end
      end
      A_Q_INIT: begin
        prv   <= '{tm: '0, tp: temp0, fn: '0};
        ptr   <= AW'(1);
        found <= 1'b0;
      end
      A_WALK: begin
        found <= hit;
        // advance past every setpoint at or before the elapsed time
        if (!hit) begin
          prv <= rd_q;
          ptr <= ptr + AW'(1);
        end
      end
      A_MUL_TEMP: begin
        span <= span_c;
        neg  <= dt[16];
        r    <= prod_t;
        dsh  <= RW'(span_c) << (QB - 1);
        q    <= '0;
        k    <= 4'(QB - 1);
      end
      A_DIV: begin
        if (ge) begin
          r <= r - dsh;
        end
        q   <= {q[QB-2:0], ge};
        dsh <= dsh >> 1;
        k   <= k - 4'd1;
      end
      A_FIX_TEMP: begin
        target_temp <= prv.tp + qn[15:0];
        neg         <= df[8];
        r           <= prod_f;
        dsh         <= RW'(span) << (QB - 1);
        q           <= '0;
        k           <= 4'(QB - 1);
      end
      A_FIX_FAN: begin
        target_fan <= prv.fn + qn[7:0];
      end
      A_HOLD: begin
        target_temp <= prv.tp;
        target_fan  <= prv.fn;
      end
      A_PROG: begin
        progress <= full ? PCT : 7'd0;
        neg      <= 1'b0;
        r        <= RW'(pct);
        dsh      <= RW'(last_time) << (QB - 1);
        q        <= '0;
        k        <= 4'(QB - 1);
      end
      A_FIX_PROG: begin
        progress <= q[6:0];
      end
      default: ;
    endcase
  end

endmodule
